/* hdl/iee_pkg.sv */
`default_nettype none

package iee_pkg;

  // Width of the internal accumulators; all arithmetic wraps at this width.
  localparam int VALUE_BITS = 32;
  // Width of the step counter of the iterative multiply/divide unit.
  localparam int CNT_BITS = $clog2(VALUE_BITS);
  // Width of the result value on the output stream.
  localparam int OUT_BITS = 32;
  // Width of one character code.
  localparam int CHAR_BITS = 8;

  // Character codes the evaluator reacts to.
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_BITS-1:0] CH_SLASH = 8'h2F;

  // Pending multiplicative operator of the current summand.
  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_MUL  = 2'd1,
    MUL_DIV  = 2'd2
  } mul_op_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic latch;       // take the input beat
    logic digit;       // append a digit to the operand
    logic unit_start;  // start a multiply or divide of product by operand
    logic fold_copy;   // product takes the operand (no pending operator)
    logic fold_take;   // product takes the multiply/divide result
    logic set_mul;     // record the multiplicative operator of the character
    logic fold_prod;   // add or subtract the product into the sum
    logic set_add;     // record the additive operator of the character
    logic finish;      // load the output register and clear the term
  } ctrl_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic is_digit;
    logic is_muldiv;
    logic is_addsub;
    logic last;
    logic mul_pending;
    logic unit_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* hdl/iee_muldiv.sv */
`default_nettype none

module iee_muldiv
  import iee_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire mul_op_t               op,
  input  wire logic [VALUE_BITS-1:0] a,
  input  wire logic [VALUE_BITS-1:0] b,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      result,
  output logic                       div_zero
);

  logic                  busy;
  logic                  fix;
  logic                  is_div;
  logic                  neg_q;
  logic [CNT_BITS-1:0]   cnt;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] opa;
  logic [VALUE_BITS-1:0] opb;
  logic [VALUE_BITS-1:0] rem;

  logic [VALUE_BITS-1:0] abs_a;
  logic [VALUE_BITS-1:0] abs_b;
  logic [VALUE_BITS-1:0] rem_sh;
  logic [VALUE_BITS:0]   diff;

  // Magnitudes of the operands; the most negative value maps onto itself,
  // which is its correct unsigned magnitude.
  assign abs_a = a[VALUE_BITS-1] ? (~a + 1'b1) : a;
  assign abs_b = b[VALUE_BITS-1] ? (~b + 1'b1) : b;

  // One restoring division step. The remainder stays below the divisor,
  // which is at most half the range, so its top bit is always zero.
  assign rem_sh = {rem[VALUE_BITS-2:0], opa[VALUE_BITS-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, opb};

  // Shift-add multiply or restoring divide, one bit per cycle, then a step to
  // fix the sign of the quotient; a division by zero returns zero, flagged.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (op == MUL_DIV && b == '0) begin
          done     <= 1'b1;
          result   <= '0;
          div_zero <= 1'b1;
        end else begin
          busy     <= 1'b1;
          cnt      <= '0;
          is_div   <= (op == MUL_DIV);
          neg_q    <= a[VALUE_BITS-1] ^ b[VALUE_BITS-1];
          acc      <= '0;
          rem      <= '0;
          div_zero <= 1'b0;
          if (op == MUL_DIV) begin
            opa <= abs_a;
            opb <= abs_b;
          end else begin
            opa <= a;
            opb <= b;
          end
        end
      end else if (busy) begin
        if (is_div) begin
          rem <= diff[VALUE_BITS] ? rem_sh : diff[VALUE_BITS-1:0];
          opa <= {opa[VALUE_BITS-2:0], ~diff[VALUE_BITS]};
        end else begin
          if (opb[0]) begin
            acc <= acc + opa;
          end
          opa <= opa << 1;
          opb <= opb >> 1;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(VALUE_BITS - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
        if (is_div) begin
          result <= neg_q ? (~opa + 1'b1) : opa;
        end else begin
          result <= acc;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/iee_datapath.sv */
`default_nettype none

module iee_datapath
  import iee_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ctrl_cmd_t            cmd,
  output ctrl_sts_t                 sts,
  input  wire logic [CHAR_BITS-1:0] s_tdata,
  input  wire logic                 s_tlast,
  input  wire logic                 m_tready,
  output logic                      m_tvalid,
  output logic [OUT_BITS-1:0]       m_tdata,
  output logic                      m_tuser
);

  logic [CHAR_BITS-1:0]         char_reg;
  logic                         last_reg;
  logic [VALUE_BITS-1:0]        number;
  logic [VALUE_BITS-1:0]        product;
  logic signed [VALUE_BITS-1:0] sum;
  logic                         add_op;
  mul_op_t                      mul_op;
  logic                         err;
  logic                         out_valid;
  logic [OUT_BITS-1:0]          out_value;
  logic                         out_dz;

  logic                  is_digit;
  logic [3:0]            digit_val;
  logic [VALUE_BITS-1:0] number_next;
  logic                  unit_done;
  logic [VALUE_BITS-1:0] unit_result;
  logic                  unit_dz;

  // Classify the held character.
  always_comb begin
    is_digit  = char_reg inside {[CH_ZERO:CH_NINE]};
    digit_val = 4'(char_reg - CH_ZERO);
  end

  // Operand times ten plus the new digit, as two shifted adds.
  assign number_next = (number << 3) + (number << 1) + VALUE_BITS'(digit_val);

  iee_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.unit_start),
    .op       (mul_op),
    .a        (product),
    .b        (number),
    .done     (unit_done),
    .result   (unit_result),
    .div_zero (unit_dz)
  );

  // Status back to the sequencer.
  always_comb begin
    sts.is_digit    = is_digit;
    sts.is_muldiv   = (char_reg == CH_STAR) || (char_reg == CH_SLASH);
    sts.is_addsub   = (char_reg == CH_PLUS) || (char_reg == CH_MINUS);
    sts.last        = last_reg;
    sts.mul_pending = (mul_op != MUL_NONE);
    sts.unit_done   = unit_done;
    sts.out_free    = !out_valid || m_tready;
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      char_reg <= s_tdata;
      last_reg <= s_tlast;
    end
  end

  // Term accumulators.
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      number  <= '0;
      product <= '0;
      sum     <= '0;
      add_op  <= 1'b0;
      mul_op  <= MUL_NONE;
      err     <= 1'b0;
    end else begin
      if (cmd.digit) begin
        number <= number_next;
      end
      if (cmd.fold_copy) begin
        product <= number;
        number  <= '0;
      end
      if (cmd.fold_take) begin
        product <= unit_result;
        number  <= '0;
        err     <= err | unit_dz;
      end
      if (cmd.set_mul) begin
        mul_op <= (char_reg == CH_STAR) ? MUL_MUL : MUL_DIV;
      end
      if (cmd.fold_prod) begin
        sum     <= add_op ? (sum - product) : (sum + product);
        product <= '0;
        mul_op  <= MUL_NONE;
      end
      if (cmd.set_add) begin
        add_op <= (char_reg == CH_MINUS);
      end
    end
  end

  // Output register; the value is sign-extended from the accumulator width.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value <= OUT_BITS'(sum);
      out_dz    <= err;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_dz;

endmodule

`default_nettype wire

/* hdl/iee_ctrl.sv */
`default_nettype none

module iee_ctrl
  import iee_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DECODE = 9'b000000010,
    ST_FOLD1  = 9'b000000100,
    ST_WAIT1  = 9'b000001000,
    ST_PROD1  = 9'b000010000,
    ST_FOLD2  = 9'b000100000,
    ST_WAIT2  = 9'b001000000,
    ST_PROD2  = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_fold1;

  // Where to go once the operand of an operator character is folded.
  always_comb begin
    if (sts.is_muldiv) begin
      after_fold1 = sts.last ? ST_FOLD2 : ST_IDLE;
    end else begin
      after_fold1 = ST_PROD1;
    end
  end

  // Sequencer: operator characters fold the operand (and for + or - the
  // product); the end of a term folds both once more and emits the sum.
  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.latch = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.digit = sts.is_digit;
        if (sts.is_muldiv || sts.is_addsub) begin
          state_next = ST_FOLD1;
        end else if (sts.last) begin
          state_next = ST_FOLD2;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FOLD1: begin
        if (sts.mul_pending) begin
          cmd.unit_start = 1'b1;
          state_next     = ST_WAIT1;
        end else begin
          cmd.fold_copy = 1'b1;
          cmd.set_mul   = sts.is_muldiv;
          state_next    = after_fold1;
        end
      end
      ST_WAIT1: begin
        if (sts.unit_done) begin
          cmd.fold_take = 1'b1;
          cmd.set_mul   = sts.is_muldiv;
          state_next    = after_fold1;
        end
      end
      ST_PROD1: begin
        cmd.fold_prod = 1'b1;
        cmd.set_add   = 1'b1;
        state_next    = sts.last ? ST_FOLD2 : ST_IDLE;
      end
      ST_FOLD2: begin
        if (sts.mul_pending) begin
          cmd.unit_start = 1'b1;
          state_next     = ST_WAIT2;
        end else begin
          cmd.fold_copy = 1'b1;
          state_next    = ST_PROD2;
        end
      end
      ST_WAIT2: begin
        if (sts.unit_done) begin
          cmd.fold_take = 1'b1;
          state_next    = ST_PROD2;
        end
      end
      ST_PROD2: begin
        cmd.fold_prod = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/integer_expression_evaluator_core.sv */
`default_nettype none

// Infix integer expression evaluator: takes a term one ASCII character per
// input beat and, after the beat marked with tlast, delivers one beat with
// the 32-bit signed value of the term and a division-by-zero flag. Digits
// build unsigned operands, * and / bind before + and -, all operators are
// left-associative, and arithmetic wraps at 32 bits; other characters are
// ignored. One character is worked on at a time. An operator that closes a
// pending multiply or divide waits on the shared shift-add/restoring-divide
// unit, which resolves one bit per cycle (32 steps, then a step that fixes
// the sign and hands back the result; a division by zero is handed back
// without the steps). The end of a term adds one more fold and a load of
// the output register. That load waits while the previous result is still
// unread; the register then holds the result while the next character is
// already accepted.
module integer_expression_evaluator_core
  import iee_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [CHAR_BITS-1:0] s_tdata,   // char_code[7:0]
  input  wire logic                 s_tlast,   // end_of_term
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [OUT_BITS-1:0]       m_tdata,   // value[31:0]
  output logic                      m_tuser    // div_by_zero
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iee_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

/* test/term_value_checker.sv */
// Watches both streams of the evaluator, works out the value of every term
// from the characters that go in, and compares each output beat with it.
module term_value_checker
  import iee_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [CHAR_BITS-1:0] s_tdata,   // char_code[7:0]
  input  logic                 s_tlast,   // end_of_term
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [OUT_BITS-1:0]  m_tdata,   // value[31:0]
  input  logic                 m_tuser,   // div_by_zero
  output int                   errors,
  output int                   terms_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                div_by_zero;
  } term_result_t;

  // Shadow copy of the evaluator state.
  logic [VALUE_BITS-1:0] run_sum;
  logic [VALUE_BITS-1:0] run_prod;
  logic [VALUE_BITS-1:0] operand;
  logic                  subtract_next;
  mul_op_t               mul_pending;
  logic                  saw_div_zero;

  term_result_t owed_q[$];

  initial begin
    errors = 0;
    terms_owed = 0;
  end

  task automatic report(input string what, input logic [OUT_BITS-1:0] got,
                        input logic [OUT_BITS-1:0] want);
    $display("MISMATCH @%0t: %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  // Truncating signed quotient for a nonzero divisor, built on magnitudes so
  // that the most negative value divided by minus one wraps cleanly.
  function automatic logic [VALUE_BITS-1:0] quotient(input logic [VALUE_BITS-1:0] a,
                                                     input logic [VALUE_BITS-1:0] b);
    logic [VALUE_BITS-1:0] mag_a;
    logic [VALUE_BITS-1:0] mag_b;
    logic [VALUE_BITS-1:0] q;
    mag_a = a[VALUE_BITS-1] ? -a : a;
    mag_b = b[VALUE_BITS-1] ? -b : b;
    q = mag_a / mag_b;
    if (a[VALUE_BITS-1] != b[VALUE_BITS-1]) begin
      q = -q;
    end
    return q;
  endfunction

  task automatic clear_term();
    run_sum = '0;
    run_prod = '0;
    operand = '0;
    subtract_next = 1'b0;
    mul_pending = MUL_NONE;
    saw_div_zero = 1'b0;
  endtask

  // Close the operand into the product of the current summand.
  task automatic fold_operand();
    case (mul_pending)
      MUL_MUL: begin
        run_prod = run_prod * operand;
      end
      MUL_DIV: begin
        if (operand == '0) begin
          saw_div_zero = 1'b1;
          run_prod = '0;
        end else begin
          run_prod = quotient(run_prod, operand);
        end
      end
      default: begin
        run_prod = operand;
      end
    endcase
    operand = '0;
  endtask

  // Close the summand into the running sum.
  task automatic fold_summand();
    run_sum = subtract_next ? run_sum - run_prod : run_sum + run_prod;
    run_prod = '0;
    mul_pending = MUL_NONE;
  endtask

  task automatic take_char(input logic [CHAR_BITS-1:0] c, input logic is_end);
    term_result_t res;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      operand = operand * 10 + VALUE_BITS'(c - CH_ZERO);
    end else if (c == CH_STAR || c == CH_SLASH) begin
      fold_operand();
      mul_pending = (c == CH_STAR) ? MUL_MUL : MUL_DIV;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      fold_operand();
      fold_summand();
      subtract_next = (c == CH_MINUS);
    end
    if (is_end) begin
      fold_operand();
      fold_summand();
      res.value = OUT_BITS'($signed(run_sum));
      res.div_by_zero = saw_div_zero;
      owed_q.push_back(res);
      clear_term();
    end
  endtask

  // Results are checked before the input beat of the same edge is taken, so
  // a term can never be matched by a beat that left before it was complete.
  always @(posedge clk) begin
    term_result_t want;
    if (rst) begin
      clear_term();
      owed_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_q.size() == 0) begin
          report("output beat with no term pending", m_tdata, '0);
        end else begin
          want = owed_q.pop_front();
          if (m_tdata !== want.value) begin
            report("value", m_tdata, want.value);
          end
          if (m_tuser !== want.div_by_zero) begin
            report("div_by_zero", OUT_BITS'(m_tuser), OUT_BITS'(want.div_by_zero));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        take_char(s_tdata, s_tlast);
      end
    end
    terms_owed = owed_q.size();
  end

endmodule

/* test/tb_integer_expression_evaluator_core.sv */
// Feeds the evaluator with directed and random terms, character by
// character, under random input gaps and output stalls.
module tb_integer_expression_evaluator_core;
  import iee_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAR_TARGET = 600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 80;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [CHAR_BITS-1:0] s_tdata;   // char_code[7:0]
  logic                 s_tlast;   // end_of_term
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_BITS-1:0]  m_tdata;   // value[31:0]
  logic                 m_tuser;   // div_by_zero

  int fail_count;
  int terms_owed;
  int burst_left;
  int chars_sent;
  int cycles;

  integer_expression_evaluator_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  term_value_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .errors     (fail_count),
    .terms_owed (terms_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output side: the stall pattern switches at random among four modes.
  initial begin
    int mode;
    int mode_left;
    m_tready = 1'b0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (mode)
        0: m_tready = 1'b1;
        1: m_tready = 1'($urandom_range(0, 1));
        2: m_tready = ($urandom_range(0, 15) == 0);
        default: m_tready = (mode_left % 5 != 0);
      endcase
    end
  end

  // Watchdog.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // One input beat; bursts of beats are separated by random gaps. Entered and
  // left at a falling edge.
  task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic is_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid = 1'b1;
    s_tdata = c;
    s_tlast = is_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    chars_sent++;
    @(negedge clk);
  endtask

  // A whole term; the mark goes on its final character.
  task automatic send_term(input string t);
    if (t.len() == 0) begin
      t = " ";
    end
    for (int i = 0; i < t.len(); i++) begin
      send_char(t[i], i == t.len() - 1);
    end
  endtask

  // Hold off input until every finished term has come out.
  task automatic drain();
    s_tvalid = 1'b0;
    while (terms_owed != 0) @(negedge clk);
  endtask

  function automatic string rand_operand();
    string t;
    int ndig;
    t = "";
    case ($urandom_range(0, 9))
      0: t = "";
      1: t = "0";
      2, 3, 4, 5, 6: ndig = $urandom_range(1, 2);
      7, 8: ndig = $urandom_range(3, 5);
      default: t = $sformatf("%0d", $urandom);
    endcase
    if (ndig > 0) begin
      for (int i = 0; i < ndig; i++) begin
        t = {t, $sformatf("%0d", $urandom_range(0, 9))};
      end
    end
    return t;
  endfunction

  function automatic string rand_operator();
    string ops;
    int k;
    ops = "+-*/";
    k = $urandom_range(0, 3);
    return ops.substr(k, k);
  endfunction

  // Random term: mostly well-formed with random content, some corner terms,
  // some raw byte noise.
  task automatic random_term();
    string t;
    int kind;
    int n_opnd;
    int nbytes;
    logic [CHAR_BITS-1:0] junk;
    t = "";
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      n_opnd = $urandom_range(1, 6);
      if ($urandom_range(0, 7) == 0) begin
        t = "-";
      end
      for (int i = 0; i < n_opnd; i++) begin
        t = {t, rand_operand()};
        if ($urandom_range(0, 11) == 0) begin
          junk = CHAR_BITS'($urandom_range(1, 255));
          t = {t, string'(junk)};
        end
        if (i < n_opnd - 1) begin
          t = {t, rand_operator()};
          if ($urandom_range(0, 14) == 0) begin
            t = {t, rand_operator()};
          end
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        t = {t, rand_operator()};
      end
      send_term(t);
    end else if (kind < 86) begin
      case ($urandom_range(0, 5))
        0: send_term("2147483648/4294967295");
        1: send_term("-2147483648");
        2: send_term({rand_operand(), "/0*", rand_operand()});
        3: send_term({"123456789012345*", rand_operand()});
        4: send_term({"4294967295*", rand_operand(), "-", rand_operand()});
        default: send_term({rand_operand(), "/-", rand_operand()});
      endcase
    end else begin
      nbytes = $urandom_range(1, 6);
      for (int i = 0; i < nbytes; i++) begin
        send_char(CHAR_BITS'($urandom_range(0, 255)), i == nbytes - 1);
      end
    end
  endtask

  initial begin
    int since_drain;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    rst = 1'b1;
    burst_left = 0;
    chars_sent = 0;
    since_drain = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed terms: empty term on the extreme codes, division by zero after
    // a leading minus, trailing operator, ignored character ending a term.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_term("-9*8/0");
    send_term("12+");
    send_term("5*3-4/2 ");
    drain();

    // Random terms, with a full drain every so often.
    while (chars_sent < CHAR_TARGET) begin
      random_term();
      since_drain++;
      if (since_drain >= 20) begin
        drain();
        since_drain = 0;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
